### design/status_frame_receiver_top_assert.svh
// Assertion helpers for the frame receiver modules; only sfr_outq uses them.
`ifndef STATUS_FRAME_RECEIVER_TOP_ASSERT_SVH
`define STATUS_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");

// Next-cycle implication, disabled while reset is active.
`define SFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");

`endif

### design/sfr_pkg.sv
package sfr_pkg;

    localparam int BUFFER_BYTES   = 512;
    localparam int POS_W          = $clog2(BUFFER_BYTES + 1);
    localparam int HEAD_DEPTH     = 9;
    localparam int FRAME_OVERHEAD = 6;
    localparam int LEN_W          = 16;
    localparam int TOTAL_W        = LEN_W + 1;
    localparam int ADDR_W         = 3;

    localparam logic [7:0] START_MARKER_RESET = 8'd3;
    localparam logic [7:0] END_MARKER_RESET   = 8'd3;

    // paddr[2] selects the register
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    localparam logic [7:0] CMD_STATUS1 = 8'd9;
    localparam logic [7:0] CMD_STATUS2 = 8'd14;
    localparam logic [7:0] CMD_STATUS3 = 8'd15;
    localparam logic [7:0] CMD_STATUS4 = 8'd16;
    localparam logic [7:0] CMD_STATUS5 = 8'd27;
    localparam logic [7:0] CMD_PONG    = 8'd18;

    typedef enum logic [2:0] {
        KIND_STATUS1   = 3'd0,
        KIND_STATUS2   = 3'd1,
        KIND_STATUS3   = 3'd2,
        KIND_STATUS4   = 3'd3,
        KIND_STATUS5   = 3'd4,
        KIND_PONG      = 3'd5,
        KIND_UNHANDLED = 3'd6,
        KIND_BAD_END   = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [LEN_W-1:0]   payload_len;
        logic signed [31:0] word_first;
        logic signed [31:0] word_second;
        logic signed [15:0] half_zero;
        logic signed [15:0] half_one;
        logic signed [15:0] half_two;
        logic signed [15:0] half_three;
        logic [31:0]        tach_magnitude;
    } result_t;

endpackage

### design/sfr_frame.sv
module sfr_frame (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        start_marker,
    input  logic [7:0]        end_marker,
    output logic              frame_done,
    output sfr_pkg::result_t  frame_result
);

    logic [sfr_pkg::POS_W-1:0]   pos_reg, pos_next, pos_inc;
    logic [sfr_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [7:0]                  head_reg [sfr_pkg::HEAD_DEPTH];
    logic [sfr_pkg::TOTAL_W-1:0] total;
    logic                        hunting;
    logic                        past_header;
    logic                        overrun;
    sfr_pkg::kind_t              cmd_kind;
    sfr_pkg::kind_t              kind;
    logic [31:0]                 w1, w2;

    assign pos_inc     = pos_reg + 1'b1;
    assign hunting     = (pos_reg == '0) && (rx_byte != start_marker);
    assign total       = {1'b0, len_reg} + sfr_pkg::TOTAL_W'(sfr_pkg::FRAME_OVERHEAD);
    assign past_header = pos_inc >= sfr_pkg::POS_W'(3);
    assign frame_done  = byte_accept && !hunting && past_header
                         && (sfr_pkg::TOTAL_W'(pos_inc) >= total);
    assign overrun     = past_header && (pos_inc >= sfr_pkg::POS_W'(sfr_pkg::BUFFER_BYTES));

    always_comb begin
        pos_next = pos_reg;
        len_next = len_reg;
        if (byte_accept && !hunting) begin
            if (pos_reg == sfr_pkg::POS_W'(1)) begin
                len_next = {rx_byte, 8'h00};
            end else if (pos_reg == sfr_pkg::POS_W'(2)) begin
                len_next = {len_reg[15:8], rx_byte};
            end
            if (frame_done || overrun) begin
                pos_next = '0;
            end else begin
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            len_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    // command byte and the first 8 data bytes
    always_ff @(posedge aclk) begin
        for (int i = 0; i < sfr_pkg::HEAD_DEPTH; i++) begin
            if (byte_accept && (pos_reg == sfr_pkg::POS_W'(i + 3))) begin
                head_reg[i] <= rx_byte;
            end
        end
    end

    // the length is settled well before the last byte, so the stored copy is current
    always_comb begin
        cmd_kind = sfr_pkg::KIND_UNHANDLED;
        priority if (len_reg == '0) begin
            cmd_kind = sfr_pkg::KIND_UNHANDLED;
        end else if (head_reg[0] == sfr_pkg::CMD_PONG) begin
            cmd_kind = sfr_pkg::KIND_PONG;
        end else if (len_reg < sfr_pkg::LEN_W'(sfr_pkg::HEAD_DEPTH)) begin
            cmd_kind = sfr_pkg::KIND_UNHANDLED;
        end else if (head_reg[0] == sfr_pkg::CMD_STATUS1) begin
            cmd_kind = sfr_pkg::KIND_STATUS1;
        end else if (head_reg[0] == sfr_pkg::CMD_STATUS2) begin
            cmd_kind = sfr_pkg::KIND_STATUS2;
        end else if (head_reg[0] == sfr_pkg::CMD_STATUS3) begin
            cmd_kind = sfr_pkg::KIND_STATUS3;
        end else if (head_reg[0] == sfr_pkg::CMD_STATUS4) begin
            cmd_kind = sfr_pkg::KIND_STATUS4;
        end else if (head_reg[0] == sfr_pkg::CMD_STATUS5) begin
            cmd_kind = sfr_pkg::KIND_STATUS5;
        end else begin
            cmd_kind = sfr_pkg::KIND_UNHANDLED;
        end
    end

    assign kind = (rx_byte == end_marker) ? cmd_kind : sfr_pkg::KIND_BAD_END;
    assign w1   = {head_reg[1], head_reg[2], head_reg[3], head_reg[4]};
    assign w2   = {head_reg[5], head_reg[6], head_reg[7], head_reg[8]};

    always_comb begin
        frame_result             = '0;
        frame_result.kind        = kind;
        frame_result.payload_len = len_reg;
        if ((kind == sfr_pkg::KIND_STATUS1) || (kind == sfr_pkg::KIND_STATUS2)
            || (kind == sfr_pkg::KIND_STATUS3) || (kind == sfr_pkg::KIND_STATUS4)
            || (kind == sfr_pkg::KIND_STATUS5)) begin
            frame_result.word_first     = w1;
            frame_result.word_second    = w2;
            frame_result.half_zero      = w1[31:16];
            frame_result.half_one       = w1[15:0];
            frame_result.half_two       = w2[31:16];
            frame_result.half_three     = w2[15:0];
            frame_result.tach_magnitude = w2[31] ? (32'd0 - w2) : w2;
        end
    end

endmodule

### design/sfr_outq.sv
`include "status_frame_receiver_top_assert.svh"

module sfr_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sfr_pkg::result_t  push_data,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output sfr_pkg::result_t  out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    sfr_pkg::result_t out_reg, out_next;
    sfr_pkg::result_t skid_reg, skid_next;
    logic             pop;
    logic             last_pop;
    logic             push_blank;
    logic             fields_zero;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop) begin
            out_valid_next  = skid_valid_reg;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (push) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_next       = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign last_pop    = pop && !push && !skid_valid_reg;
    assign push_blank  = push && ((push_data.kind == sfr_pkg::KIND_PONG)
                                  || (push_data.kind == sfr_pkg::KIND_UNHANDLED)
                                  || (push_data.kind == sfr_pkg::KIND_BAD_END));
    assign fields_zero = (push_data.word_first == '0) && (push_data.word_second == '0)
                         && (push_data.tach_magnitude == '0);

    `SFR_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `SFR_ASSERT_NOW(a_no_push_when_full, aclk, aresetn, push, !skid_valid_reg)
    `SFR_ASSERT_NEXT(a_drain_empties, aclk, aresetn, last_pop, !out_valid_reg)
    `SFR_ASSERT_NOW(a_blank_fields, aclk, aresetn, push_blank, fields_zero)

endmodule

### design/status_frame_receiver_top.sv
// Byte-stream frame receiver: hunts for the start marker, reads a 16-bit big-endian
// length, the payload, two CRC bytes (not checked) and the end marker, and returns one
// decoded result per complete frame. One byte is accepted every clock cycle while s_ready
// is high; the framing state (byte position, length, first nine payload bytes) is
// updated in the same cycle, and a result is registered into the output queue when the
// last byte of its frame is accepted. A two-entry output queue lets bytes keep flowing
// while a result waits; s_ready drops only when both entries hold results. Frames longer
// than the buffer size are dropped without a result. Markers are set over the APB port.
module status_frame_receiver_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_kind,
    output logic [15:0]                m_payload_len,
    output logic signed [31:0]         m_word_first,
    output logic signed [31:0]         m_word_second,
    output logic signed [15:0]         m_half_zero,
    output logic signed [15:0]         m_half_one,
    output logic signed [15:0]         m_half_two,
    output logic signed [15:0]         m_half_three,
    output logic [31:0]                m_tach_magnitude
);

    logic [7:0]       start_marker_reg;
    logic [7:0]       end_marker_reg;
    logic             cfg_write;
    logic             byte_accept;
    logic             frame_done;
    sfr_pkg::result_t frame_result;
    sfr_pkg::result_t out_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= sfr_pkg::START_MARKER_RESET;
            end_marker_reg   <= sfr_pkg::END_MARKER_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == sfr_pkg::REG_START_MARKER) begin
                start_marker_reg <= pwdata[7:0];
            end else begin
                end_marker_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = {24'd0, (paddr[2] == sfr_pkg::REG_END_MARKER) ? end_marker_reg
                                                                  : start_marker_reg};

    assign byte_accept = s_valid && s_ready;

    sfr_frame u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .rx_byte      (s_rx_byte),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .frame_done   (frame_done),
        .frame_result (frame_result)
    );

    sfr_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (frame_done),
        .push_data (frame_result),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_kind           = out_data.kind;
    assign m_payload_len    = out_data.payload_len;
    assign m_word_first     = out_data.word_first;
    assign m_word_second    = out_data.word_second;
    assign m_half_zero      = out_data.half_zero;
    assign m_half_one       = out_data.half_one;
    assign m_half_two       = out_data.half_two;
    assign m_half_three     = out_data.half_three;
    assign m_tach_magnitude = out_data.tach_magnitude;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int HOLD_CYCLES = 400;
    // the receiver hold-off is the longest quiet stretch of a correct run
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MIN_RESULTS = 3;
    localparam logic [sfr_pkg::ADDR_W-1:0] START_ADDR = {sfr_pkg::REG_START_MARKER, 2'b00};
    localparam logic [sfr_pkg::ADDR_W-1:0] END_ADDR   = {sfr_pkg::REG_END_MARKER, 2'b00};

    typedef struct {
        int               noise_n;
        logic [15:0]      len;
        logic [7:0]       cmd;
        logic [63:0]      data;
        bit               good_end;
        bit               typed;
        sfr_pkg::result_t want;
    } frame_row_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [sfr_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                pwdata    = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic [7:0]                 s_rx_byte = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic [2:0]                 m_kind;
    logic [15:0]                m_payload_len;
    logic signed [31:0]         m_word_first;
    logic signed [31:0]         m_word_second;
    logic signed [15:0]         m_half_zero;
    logic signed [15:0]         m_half_one;
    logic signed [15:0]         m_half_two;
    logic signed [15:0]         m_half_three;
    logic [31:0]                m_tach_magnitude;

    // deframer model state
    logic [16:0]      frame_pos = '0;
    logic [15:0]      frame_len = '0;
    logic [7:0]       frame_head [sfr_pkg::HEAD_DEPTH];
    logic [7:0]       start_mk = sfr_pkg::START_MARKER_RESET;
    logic [7:0]       end_mk   = sfr_pkg::END_MARKER_RESET;
    sfr_pkg::result_t pending_results [$];

    frame_row_t       frame_rows [16];
    sfr_pkg::result_t got_res;
    sfr_pkg::result_t want_res;

    int send_idle_pct = 24;
    int recv_idle_pct = 82;
    int hold_req = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int results_seen = 0;
    int results_predicted = 0;
    int bytes_in = 0;
    int frames_dropped = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    status_frame_receiver_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_payload_len   (m_payload_len),
        .m_word_first    (m_word_first),
        .m_word_second   (m_word_second),
        .m_half_zero     (m_half_zero),
        .m_half_one      (m_half_one),
        .m_half_two      (m_half_two),
        .m_half_three    (m_half_three),
        .m_tach_magnitude(m_tach_magnitude)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic sfr_pkg::kind_t frame_kind();
        if (frame_len == 16'd0) return sfr_pkg::KIND_UNHANDLED;
        if (frame_head[0] == sfr_pkg::CMD_PONG) return sfr_pkg::KIND_PONG;
        if (frame_len < sfr_pkg::HEAD_DEPTH) return sfr_pkg::KIND_UNHANDLED;
        case (frame_head[0])
            sfr_pkg::CMD_STATUS1: return sfr_pkg::KIND_STATUS1;
            sfr_pkg::CMD_STATUS2: return sfr_pkg::KIND_STATUS2;
            sfr_pkg::CMD_STATUS3: return sfr_pkg::KIND_STATUS3;
            sfr_pkg::CMD_STATUS4: return sfr_pkg::KIND_STATUS4;
            sfr_pkg::CMD_STATUS5: return sfr_pkg::KIND_STATUS5;
            default:              return sfr_pkg::KIND_UNHANDLED;
        endcase
    endfunction

    // advance the deframer by one byte; done is set when a frame closes
    task automatic decode_byte(input logic [7:0] b, output bit done,
                               output sfr_pkg::result_t r);
        logic [16:0]     total;
        logic [31:0]     w2;
        sfr_pkg::kind_t  k;
        done = 1'b0;
        r = '0;
        if (frame_pos == 17'd0 && b != start_mk) return;
        if (frame_pos == 17'd1) frame_len = {b, 8'h00};
        else if (frame_pos == 17'd2) frame_len[7:0] = b;
        else if (frame_pos >= 17'd3 && frame_pos < 17'd3 + sfr_pkg::HEAD_DEPTH)
            frame_head[4'(frame_pos - 17'd3)] = b;
        frame_pos = frame_pos + 17'd1;
        if (frame_pos < 17'd3) return;
        total = {1'b0, frame_len} + 17'(sfr_pkg::FRAME_OVERHEAD);
        if (frame_pos >= total) begin
            frame_pos = '0;
            done = 1'b1;
            k = (b == end_mk) ? frame_kind() : sfr_pkg::KIND_BAD_END;
            r.kind = k;
            r.payload_len = frame_len;
            if (k <= sfr_pkg::KIND_STATUS5) begin
                w2 = {frame_head[5], frame_head[6], frame_head[7], frame_head[8]};
                r.word_first  = {frame_head[1], frame_head[2], frame_head[3], frame_head[4]};
                r.word_second = w2;
                r.half_zero   = {frame_head[1], frame_head[2]};
                r.half_one    = {frame_head[3], frame_head[4]};
                r.half_two    = {frame_head[5], frame_head[6]};
                r.half_three  = {frame_head[7], frame_head[8]};
                r.tach_magnitude = w2[31] ? 32'd0 - w2 : w2;
            end
        end else if (frame_pos >= sfr_pkg::BUFFER_BYTES) begin
            // overrun: frame dropped, back to hunting
            frame_pos = '0;
            frames_dropped++;
        end
    endtask

    function automatic sfr_pkg::result_t mk_result(sfr_pkg::kind_t kind, logic [15:0] len,
                                                   logic [31:0] w1, logic [31:0] w2,
                                                   logic [15:0] h0, logic [15:0] h1,
                                                   logic [15:0] h2, logic [15:0] h3,
                                                   logic [31:0] tach);
        sfr_pkg::result_t r;
        r.kind = kind;
        r.payload_len = len;
        r.word_first = w1;
        r.word_second = w2;
        r.half_zero = h0;
        r.half_one = h1;
        r.half_two = h2;
        r.half_three = h3;
        r.tach_magnitude = tach;
        return r;
    endfunction

    function automatic frame_row_t mk_row(int noise_n, logic [15:0] len, logic [7:0] cmd,
                                          logic [63:0] data, bit good_end, bit typed,
                                          sfr_pkg::result_t want);
        frame_row_t row;
        row.noise_n = noise_n;
        row.len = len;
        row.cmd = cmd;
        row.data = data;
        row.good_end = good_end;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic string show(sfr_pkg::result_t r);
        return $sformatf("kind=%0d len=%0d w1=%0d w2=%0d h=%0d/%0d/%0d/%0d tach=%0d",
                         r.kind, r.payload_len, r.word_first, r.word_second, r.half_zero,
                         r.half_one, r.half_two, r.half_three, r.tach_magnitude);
    endfunction

    // called at a falling edge, returns at a falling edge; valid stays high for the next byte
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input sfr_pkg::result_t want);
        bit               done;
        sfr_pkg::result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(b, done, r);
        if (done) begin
            pending_results.push_back(typed ? want : r);
            results_predicted++;
        end
        bytes_in++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] lead, input logic [15:0] len,
                              input logic [7:0] cmd, input logic [63:0] data,
                              input bit good_end, input int cap, input bit typed,
                              input sfr_pkg::result_t want);
        int         n;
        int         last;
        logic [7:0] b;
        last = int'(len) + sfr_pkg::FRAME_OVERHEAD - 1;
        n = (last + 1 < cap) ? last + 1 : cap;
        for (int i = 0; i < n; i++) begin
            if (i == 0) b = lead;
            else if (i == 1) b = len[15:8];
            else if (i == 2) b = len[7:0];
            else if (i - 3 < int'(len)) begin
                if (i == 3) b = cmd;
                else if (i <= 11) b = data[(11 - i) * 8 +: 8];
                else b = 8'($urandom);
            end else if (i == last) b = good_end ? end_mk : ~end_mk;
            else b = 8'($urandom);   // crc bytes, never checked
            send_byte(b, typed && i == last, want);
        end
    endtask

    task automatic random_frames(input int want_bytes);
        int          first_byte;
        int          first_res;
        int          roll;
        int          cap;
        int          noise;
        logic [15:0] len;
        logic [7:0]  cmd;
        logic [7:0]  lead;
        logic [7:0]  nb;
        bit          good_end;
        first_byte = bytes_in;
        first_res = results_predicted;
        while (bytes_in - first_byte < want_bytes
               || results_predicted - first_res < MIN_RESULTS) begin
            roll = $urandom_range(99);
            if (roll < 80) len = 16'($urandom_range(0, 16));
            else if (roll < 96) len = 16'($urandom_range(9, 40));
            else len = 16'($urandom_range(41, 120));
            if ($urandom_range(99) < 80) begin
                case ($urandom_range(5))
                    0: cmd = sfr_pkg::CMD_STATUS1;
                    1: cmd = sfr_pkg::CMD_STATUS2;
                    2: cmd = sfr_pkg::CMD_STATUS3;
                    3: cmd = sfr_pkg::CMD_STATUS4;
                    4: cmd = sfr_pkg::CMD_STATUS5;
                    default: cmd = sfr_pkg::CMD_PONG;
                endcase
            end else begin
                cmd = 8'($urandom);
            end
            good_end = ($urandom_range(9) != 0);
            cap = int'(len) + sfr_pkg::FRAME_OVERHEAD;
            if ($urandom_range(29) == 0) cap = $urandom_range(1, cap - 1);   // truncated frame
            lead = ($urandom_range(32) == 0) ? 8'($urandom) : start_mk;
            if ($urandom_range(4) == 0) begin
                noise = $urandom_range(1, 4);
                repeat (noise) begin
                    nb = 8'($urandom);
                    if (nb == start_mk) nb = nb ^ 8'h80;
                    send_byte(nb, 1'b0, '0);
                end
            end
            send_frame(lead, len, cmd, {$urandom, $urandom}, good_end, cap, 1'b0, '0);
        end
    endtask

    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [sfr_pkg::ADDR_W-1:0] addr, input logic [7:0] value);
        logic [31:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {junk[31:8], value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == START_ADDR) start_mk = value;
        else end_mk = value;
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_res.kind           = sfr_pkg::kind_t'(m_kind);
            got_res.payload_len    = m_payload_len;
            got_res.word_first     = m_word_first;
            got_res.word_second    = m_word_second;
            got_res.half_zero      = m_half_zero;
            got_res.half_one       = m_half_one;
            got_res.half_two       = m_half_two;
            got_res.half_three     = m_half_three;
            got_res.tach_magnitude = m_tach_magnitude;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %s", show(got_res));
            end else begin
                want_res = pending_results.pop_front();
                if (got_res !== want_res) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch %0d expected %s", mismatches, show(want_res));
                        $display("mismatch %0d actual   %s", mismatches, show(got_res));
                    end
                end
            end
        end
    end

    // receiver side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_served != hold_req) begin
            hold_served = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (frame_head[i]) frame_head[i] = '0;
        frame_rows[0]  = mk_row(3, 16'd9, sfr_pkg::CMD_STATUS1, 64'h0, 1, 1,
                                mk_result(sfr_pkg::KIND_STATUS1, 16'd9, 0, 0, 0, 0, 0, 0, 0));
        frame_rows[1]  = mk_row(0, 16'd9, sfr_pkg::CMD_STATUS1, {64{1'b1}}, 1, 1,
                                mk_result(sfr_pkg::KIND_STATUS1, 16'd9, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF, 32'd1));
        frame_rows[2]  = mk_row(0, 16'd9, sfr_pkg::CMD_STATUS2, 64'h7FFF_FFFF_7FFF_FFFF, 1, 1,
                                mk_result(sfr_pkg::KIND_STATUS2, 16'd9, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF,
                                          16'hFFFF, 32'h7FFF_FFFF));
        // most negative tachometer word: magnitude does not fit a signed word
        frame_rows[3]  = mk_row(2, 16'd20, sfr_pkg::CMD_STATUS3, 64'h8000_0000_8000_0000, 1, 1,
                                mk_result(sfr_pkg::KIND_STATUS3, 16'd20, 32'h8000_0000,
                                          32'h8000_0000, 16'h8000, 16'h0, 16'h8000, 16'h0,
                                          32'h8000_0000));
        frame_rows[4]  = mk_row(0, 16'd12, sfr_pkg::CMD_STATUS4, 64'h0123_4567_89AB_CDEF,
                                1, 0, '0);
        frame_rows[5]  = mk_row(0, 16'd9, sfr_pkg::CMD_STATUS5, 64'hFEDC_BA98_7654_3210,
                                1, 0, '0);
        frame_rows[6]  = mk_row(0, 16'd1, sfr_pkg::CMD_PONG, 64'h0, 1, 1,
                                mk_result(sfr_pkg::KIND_PONG, 16'd1, 0, 0, 0, 0, 0, 0, 0));
        frame_rows[7]  = mk_row(1, 16'd30, sfr_pkg::CMD_PONG, 64'h1122_3344_5566_7788, 1, 1,
                                mk_result(sfr_pkg::KIND_PONG, 16'd30, 0, 0, 0, 0, 0, 0, 0));
        frame_rows[8]  = mk_row(0, 16'd8, sfr_pkg::CMD_STATUS1, 64'hAAAA_5555_AAAA_5555, 1, 1,
                                mk_result(sfr_pkg::KIND_UNHANDLED, 16'd8,
                                          0, 0, 0, 0, 0, 0, 0));
        frame_rows[9]  = mk_row(0, 16'd0, sfr_pkg::CMD_STATUS1, 64'h0, 1, 1,
                                mk_result(sfr_pkg::KIND_UNHANDLED, 16'd0,
                                          0, 0, 0, 0, 0, 0, 0));
        frame_rows[10] = mk_row(0, 16'd9, 8'hFF, 64'h1234_5678_9ABC_DEF0, 1, 1,
                                mk_result(sfr_pkg::KIND_UNHANDLED, 16'd9,
                                          0, 0, 0, 0, 0, 0, 0));
        frame_rows[11] = mk_row(0, 16'd9, sfr_pkg::CMD_STATUS1, 64'h0F0F_0F0F_F0F0_F0F0, 0, 1,
                                mk_result(sfr_pkg::KIND_BAD_END, 16'd9, 0, 0, 0, 0, 0, 0, 0));
        frame_rows[12] = mk_row(0, 16'd1, sfr_pkg::CMD_PONG, 64'h0, 0, 1,
                                mk_result(sfr_pkg::KIND_BAD_END, 16'd1, 0, 0, 0, 0, 0, 0, 0));
        // exactly fills the buffer, then one that overruns it
        frame_rows[13] = mk_row(0, 16'd506, sfr_pkg::CMD_STATUS5, 64'h0000_0001_8000_0001,
                                1, 0, '0);
        frame_rows[14] = mk_row(0, 16'hFFFF, sfr_pkg::CMD_STATUS1, 64'h0, 1, 0, '0);
        frame_rows[15] = mk_row(1, 16'd9, sfr_pkg::CMD_STATUS2, 64'h0, 1, 1,
                                mk_result(sfr_pkg::KIND_STATUS2, 16'd9, 0, 0, 0, 0, 0, 0, 0));

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (frame_rows[i]) begin
            repeat (frame_rows[i].noise_n) send_byte(start_mk ^ 8'h55, 1'b0, '0);
            send_frame(start_mk, frame_rows[i].len, frame_rows[i].cmd, frame_rows[i].data,
                       frame_rows[i].good_end, sfr_pkg::BUFFER_BYTES, frame_rows[i].typed,
                       frame_rows[i].want);
        end

        drain_results(SETTLE_CYCLES);
        write_reg(START_ADDR, 8'h00);
        write_reg(END_ADDR, 8'hFF);
        random_frames(90);

        drain_results(SETTLE_CYCLES);
        write_reg(START_ADDR, 8'hFF);
        write_reg(END_ADDR, 8'h00);
        send_idle_pct = 82;
        recv_idle_pct = 24;
        random_frames(90);

        drain_results(SETTLE_CYCLES);
        write_reg(START_ADDR, 8'($urandom));
        write_reg(END_ADDR, 8'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_frames(40);
        hold_req++;   // receiver stalls while bytes keep coming
        random_frames(50);
        drain_results(0);
        random_frames(30);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("run: %0d bytes in, %0d results checked, %0d oversize frames dropped",
                 bytes_in, results_seen, frames_dropped);
        $display("run: %0d marker writes (reset, 00/ff, ff/00, random), three stall mixes",
                 reg_writes);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
